>>> sv/lfu_pkg.sv
package lfu_pkg;

  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 32;
  localparam int STAMP_BITS  = 48;
  localparam int CAP_BITS    = 5;
  localparam int ENTRIES_DEF = 16;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // register index as seen on paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                         operation;
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
  } lfu_rsp_t;

endpackage

>>> sv/lfu_match.sv
module lfu_match #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]                        valid_i,
  input  logic [ENTRIES-1:0][lfu_pkg::KEY_BITS-1:0] keys_i,
  input  logic [lfu_pkg::KEY_BITS-1:0]              key_i,
  output logic                                      hit_o,
  output logic [IW-1:0]                             idx_o
);
  import lfu_pkg::*;

  // descending scan so the lowest matching slot wins
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        hit_o = 1'b1;
        idx_o = IW'(i);
      end
    end
  end

endmodule

>>> sv/lfu_victim.sv
module lfu_victim #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]                          valid_i,
  input  logic [ENTRIES-1:0][lfu_pkg::COUNT_BITS-1:0] cnt_i,
  input  logic [ENTRIES-1:0][lfu_pkg::STAMP_BITS-1:0] stp_i,
  output logic                                        have_o,
  output logic [IW-1:0]                               idx_o
);
  import lfu_pkg::*;

  localparam int LVL = (ENTRIES > 1) ? $clog2(ENTRIES) : 0;
  localparam int P   = 1 << LVL;
  localparam int RW  = COUNT_BITS + STAMP_BITS;

  logic          nv [2*P];
  logic [RW-1:0] nr [2*P];
  logic [IW-1:0] ni [2*P];
  logic          take_r;

  // min tree on {count, stamp}; the left child is kept on a tie, so the
  // lowest slot index wins among equal ranks
  always_comb begin
    take_r = 1'b0;
    for (int n = 0; n < 2 * P; n++) begin
      nv[n] = 1'b0;
      nr[n] = '0;
      ni[n] = '0;
    end
    for (int i = 0; i < P; i++) begin
      if (i < ENTRIES) begin
        nv[P+i] = valid_i[i];
        nr[P+i] = {cnt_i[i], stp_i[i]};
        ni[P+i] = IW'(i);
      end
    end
    for (int n = P - 1; n >= 1; n--) begin
      take_r = nv[2*n+1] && (!nv[2*n] || (nr[2*n+1] < nr[2*n]));
      nv[n]  = nv[2*n] || nv[2*n+1];
      nr[n]  = take_r ? nr[2*n+1] : nr[2*n];
      ni[n]  = take_r ? ni[2*n+1] : ni[2*n];
    end
  end

  assign have_o = nv[1];
  assign idx_o  = ni[1];

endmodule

>>> sv/lfu_cache_table.sv
// channel   ports                                    transfer
// -------   -----------------------------------      -----------------------------
// command   start, busy, cmd_i                       start high and busy low
// result    done_o, rsp_o                            done_o high, one cycle, no stall
// config    psel, penable, pwrite, paddr, pwdata,    psel & penable & pwrite & pready
//           prdata, pready
//
// one command every cycle; each command is captured in the input register, goes through the
// combinational key match and the min tree over all entries, and its result is registered
// onto done_o and rsp_o. busy is always low. reset empties the table, clears the sequence
// counter and sets capacity to 16. results cannot be held off by the receiver.
module lfu_cache_table #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  lfu_pkg::lfu_req_t                 cmd_i,
  output logic                              done_o,
  output lfu_pkg::lfu_rsp_t                 rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfu_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [lfu_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [lfu_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OC = $clog2(ENTRIES + 1);
  localparam int OW = (OC > CAP_BITS) ? OC : CAP_BITS;

  // configuration
  logic [CAP_BITS-1:0] capacity_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_BITS'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_BITS-1:0];
    end
  end

  // input register
  logic     req_vld_q;
  lfu_req_t req_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= cmd_i;
    end
  end

  // table state
  logic [ENTRIES-1:0]                  valid_q;
  logic [ENTRIES-1:0][KEY_BITS-1:0]    key_q;
  logic [ENTRIES-1:0][VALUE_BITS-1:0]  val_q;
  logic [ENTRIES-1:0][COUNT_BITS-1:0]  cnt_q;
  logic [ENTRIES-1:0][STAMP_BITS-1:0]  stp_q;
  logic [STAMP_BITS-1:0]               seq_q;

  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic                have_victim;
  logic [IW-1:0]       victim_idx;

  lfu_match #(.ENTRIES(ENTRIES)) u_match (
    .valid_i (valid_q),
    .keys_i  (key_q),
    .key_i   (req_q.key),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  lfu_victim #(.ENTRIES(ENTRIES)) u_victim (
    .valid_i (valid_q),
    .cnt_i   (cnt_q),
    .stp_i   (stp_q),
    .have_o  (have_victim),
    .idx_o   (victim_idx)
  );

  logic [OW-1:0]         occ;
  logic [OW-1:0]         cap_eff;
  logic                  touch_en;
  logic                  ins_en;
  logic                  evict_en;
  logic [ENTRIES-1:0]    valid_kept;
  logic [IW-1:0]         free_idx;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [ENTRIES-1:0]    valid_d;
  lfu_rsp_t              rsp_d;

  assign occ     = OW'($countones(valid_q));
  assign cap_eff = (OW'(capacity_q) > OW'(ENTRIES)) ? OW'(ENTRIES) : OW'(capacity_q);

  assign touch_en = req_vld_q && hit;
  assign ins_en   = req_vld_q && (req_q.operation == OP_PUT) && !hit && (cap_eff != '0);
  assign evict_en = ins_en && (occ >= cap_eff) && have_victim;
  assign cnt_inc  = (cnt_q[hit_idx] == '1) ? cnt_q[hit_idx]
                                           : cnt_q[hit_idx] + COUNT_BITS'(1);

  // first free slot once the victim, if any, is dropped
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      valid_kept[i] = valid_q[i] && !(evict_en && (victim_idx == IW'(i)));
      if (!valid_kept[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ins_en) begin
      valid_d           = valid_kept;
      valid_d[free_idx] = 1'b1;
    end
  end

  always_comb begin
    rsp_d.hit = hit;
    if (req_q.operation == OP_GET) begin
      rsp_d.read_value = hit ? signed'(val_q[hit_idx]) : MISS_VALUE;
    end else begin
      rsp_d.read_value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seq_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_o  <= req_vld_q;
      if (touch_en || ins_en) begin
        seq_q <= seq_q + STAMP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_o <= rsp_d;
    end
    if (touch_en) begin
      cnt_q[hit_idx] <= cnt_inc;
      stp_q[hit_idx] <= seq_q;
      if (req_q.operation == OP_PUT) begin
        val_q[hit_idx] <= req_q.value;
      end
    end else if (ins_en) begin
      key_q[free_idx] <= req_q.key;
      val_q[free_idx] <= req_q.value;
      cnt_q[free_idx] <= COUNT_BITS'(1);
      stp_q[free_idx] <= seq_q;
    end
  end

`ifndef ASSERT_OFF
  a_insert_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_en |=> valid_q[$past(free_idx)])
    else $error("inserted entry not marked valid");

  a_seq_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(touch_en || ins_en) |=> seq_q == $past(seq_q))
    else $error("sequence counter moved without a stamp");

  a_victim_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_en |-> valid_q[victim_idx])
    else $error("eviction picked an empty slot");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    touch_en |-> valid_q[hit_idx])
    else $error("hit on an empty slot");
`endif

endmodule

>>> tb/lfu_cache_table_tb.sv
`timescale 1ns / 1ps

module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int PHASE_ITEMS = 58;
  localparam int POOL_MAX    = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_ADDR_BITS-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  class lfu_result_board;
    bit                           slot_used  [ENTRIES_DEF];
    logic [KEY_BITS-1:0]          slot_key   [ENTRIES_DEF];
    logic signed [VALUE_BITS-1:0] slot_val   [ENTRIES_DEF];
    bit [COUNT_BITS-1:0]          slot_uses  [ENTRIES_DEF];
    bit [STAMP_BITS-1:0]          slot_stamp [ENTRIES_DEF];
    bit [STAMP_BITS-1:0]          access_seq;
    bit [CAP_BITS-1:0]            capacity;
    lfu_rsp_t                     pending_rsp[$];
    int                           errors;
    int                           commands;
    int                           results;
    int                           hits;
    int                           evictions;
    int                           cap_writes;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      access_seq = '0;
      capacity   = CAP_RESET;
    endfunction

    function void set_capacity(bit [CAP_BITS-1:0] cap);
      capacity = cap;
      cap_writes++;
    endfunction

    // count saturates, stamp comes from the wrapping access sequence
    function void credit_use(int idx);
      if (slot_uses[idx] != '1) slot_uses[idx]++;
      slot_stamp[idx] = access_seq;
      access_seq++;
    endfunction

    function void note_command(lfu_req_t req);
      lfu_rsp_t exp_rsp;
      int       found;
      int       victim;
      int       occupied;
      int       limit;
      found    = -1;
      victim   = -1;
      occupied = 0;
      limit    = (capacity > ENTRIES_DEF) ? ENTRIES_DEF : int'(capacity);
      commands++;
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (slot_used[i]) begin
          occupied++;
          if (found < 0 && slot_key[i] == req.key) found = i;
        end
      end
      exp_rsp.hit        = (found >= 0);
      exp_rsp.read_value = '0;
      if (found >= 0) hits++;
      if (req.operation == OP_GET) begin
        if (found >= 0) begin
          credit_use(found);
          exp_rsp.read_value = slot_val[found];
        end else begin
          exp_rsp.read_value = MISS_VALUE;
        end
      end else if (found >= 0) begin
        slot_val[found] = req.value;
        credit_use(found);
      end else if (limit != 0) begin
        // full (or shrunk below occupancy): drop exactly one entry first
        if (occupied >= limit) begin
          for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] &&
                 slot_stamp[i] < slot_stamp[victim]))) begin
              victim = i;
            end
          end
          if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            evictions++;
          end
        end
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]  = 1'b1;
            slot_key[i]   = req.key;
            slot_val[i]   = req.value;
            slot_uses[i]  = 1;
            slot_stamp[i] = access_seq;
            access_seq++;
            break;
          end
        end
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void check_result(lfu_rsp_t rsp);
      lfu_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("result with no transaction outstanding: hit %0b read_value %0d",
               rsp.hit, rsp.read_value);
        errors++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      results++;
      if (rsp.hit !== exp_rsp.hit) begin
        $error("hit mismatch: expected %0b, actual %0b", exp_rsp.hit, rsp.hit);
        errors++;
      end
      if (rsp.read_value !== exp_rsp.read_value) begin
        $error("read_value mismatch: expected %0d, actual %0d",
               exp_rsp.read_value, rsp.read_value);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni  = 1'b0;
  logic                     start   = 1'b0;
  logic                     busy;
  lfu_req_t                 cmd_i   = '0;
  logic                     done_o;
  lfu_rsp_t                 rsp_o;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr   = '0;
  logic [CFG_DATA_BITS-1:0] pwdata  = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  lfu_result_board board = new();
  bit                      quiet_stretch = 1'b0;
  int unsigned             cycle_count = 0;

  lfu_cache_table dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lfu_cache_table verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(rsp_o);
  end

  task automatic send_cmd(input logic op, input logic [KEY_BITS-1:0] key,
                          input logic [VALUE_BITS-1:0] value);
    lfu_req_t req;
    lfu_req_t noise;
    int       gap;
    req.operation = op;
    req.key       = key;
    req.value     = value;
    gap = quiet_stretch ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      // garbage on the command bus while start is low must be ignored
      noise.operation = 1'($urandom);
      noise.key       = $urandom;
      noise.value     = $urandom;
      start <= 1'b0;
      cmd_i <= noise;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= req;
    do @(posedge clk_i); while (busy);
    board.note_command(req);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write the register, then read it back in the next transaction
  task automatic retune_capacity(input logic [CAP_BITS-1:0] cap);
    logic [CFG_DATA_BITS-1:0] wdata;
    wdata = $urandom;
    wdata[CAP_BITS-1:0] = cap;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_capacity(cap);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== CFG_DATA_BITS'(cap)) begin
      $error("capacity mismatch: expected %0d, actual %0d", cap, prdata);
      board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [KEY_BITS-1:0] key_pool [POOL_MAX];
    logic [CAP_BITS-1:0] phase_caps [9];
    logic [KEY_BITS-1:0] key;
    int                  pool_size;
    int                  eff_cap;

    phase_caps = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd17, 5'd2, 5'd12};
    phase_caps[8] = CAP_BITS'($urandom_range(1, 16));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity: extremes of key and value, update in place
    quiet_stretch = 1'b0;
    send_cmd(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_cmd(OP_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_cmd(OP_PUT, 32'hffff_ffff, 32'h8000_0000);
    send_cmd(OP_GET, 32'h0000_0000, 32'hffff_ffff);
    send_cmd(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    send_cmd(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_GET, 32'h0000_0000, 32'h0000_0000);

    // two entries: lowest use count goes first
    retune_capacity(5'd2);
    send_cmd(OP_PUT, 32'h55aa_55aa, 32'h1234_5678);
    send_cmd(OP_GET, 32'hffff_ffff, 32'h0);
    send_cmd(OP_GET, 32'h55aa_55aa, 32'h0);
    send_cmd(OP_PUT, 32'haa55_aa55, 32'hcafe_f00d);

    // equal counts: the older entry is dropped
    retune_capacity(5'd3);
    send_cmd(OP_PUT, 32'h0000_ffff, 32'h0bad_0bad);
    send_cmd(OP_PUT, 32'hffff_0000, 32'hdead_0001);
    send_cmd(OP_GET, 32'haa55_aa55, 32'h0);

    // capacity below occupancy: one eviction per insert, no more
    retune_capacity(5'd1);
    send_cmd(OP_PUT, 32'h1357_9bdf, 32'h2468_ace0);
    send_cmd(OP_GET, 32'h0000_0000, 32'h0);
    send_cmd(OP_PUT, 32'h0000_0000, 32'h5a5a_5a5a);

    // zero capacity stores nothing new, old entries still hit
    retune_capacity(5'd0);
    send_cmd(OP_PUT, 32'hdead_beef, 32'h1111_1111);
    send_cmd(OP_GET, 32'hdead_beef, 32'h0);
    send_cmd(OP_GET, 32'h0000_0000, 32'h0);

    // above the table size acts as full size
    retune_capacity(5'd31);
    send_cmd(OP_PUT, 32'h8000_0001, 32'hffff_fffe);
    send_cmd(OP_PUT, 32'h7fff_fffe, 32'h0000_0001);
    send_cmd(OP_GET, 32'h8000_0001, 32'h0);
    send_cmd(OP_GET, 32'h7fff_fffe, 32'h0);

    foreach (phase_caps[ph]) begin
      retune_capacity(phase_caps[ph]);
      eff_cap   = (phase_caps[ph] > ENTRIES_DEF) ? ENTRIES_DEF : int'(phase_caps[ph]);
      pool_size = eff_cap + $urandom_range(1, 6);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int p = 0; p < pool_size; p++) key_pool[p] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) quiet_stretch = !quiet_stretch;
        // mostly reuse a small key set so hits and evictions stay frequent
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        send_cmd(1'($urandom_range(0, 1)), key, $urandom);
      end
    end

    drain_results();
    $display("ran %0d transactions, %0d results checked: %0d hits, %0d evictions",
             board.commands, board.results, board.hits, board.evictions);
    $display("capacity written %0d times, including 0, 1, 16 and values above 16",
             board.cap_writes);
    if (board.errors == 0) begin
      $display("lfu_cache_table verification clean");
    end else begin
      $display("lfu_cache_table verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lfu_pkg.sv
sv/lfu_match.sv
sv/lfu_victim.sv
sv/lfu_cache_table.sv
tb/lfu_cache_table_tb.sv
